[hw/rtl/rotor_phase_estimator_assert.svh]
// Assertion macros shared by the rotor phase estimator RTL.
`ifndef ROTOR_PHASE_ESTIMATOR_ASSERT_SVH
`define ROTOR_PHASE_ESTIMATOR_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define RPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define RPE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RPE_ASSERT_IMP(label, ante, cons, msg)
`define RPE_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[hw/rtl/rpe_pkg.sv]
// Constants, codes and types shared by the rotor phase estimator modules.
package rpe_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int ANGLE_BITS    = 12;
  localparam int TIME_W        = 32;
  localparam int PERIOD_W      = 21;
  localparam int SUM_W         = PERIOD_W + $clog2(HISTORY_DEPTH);
  localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int STEP_W        = $clog2(SUM_W + 1);
  localparam int TURN_COUNTS   = 1 << ANGLE_BITS;
  localparam int WRAP_W        = ANGLE_BITS + 3;

  // Wrap test thresholds: angle * 6 compared against 5 turns and 1 turn.
  localparam logic [WRAP_W-1:0] WRAP_HIGH = WRAP_W'(5 * TURN_COUNTS);
  localparam logic [WRAP_W-1:0] WRAP_LOW  = WRAP_W'(TURN_COUNTS);

  // Motor offsets of one and two thirds of a turn, rounded.
  localparam logic [ANGLE_BITS-1:0] MOTOR2_OFFSET = ANGLE_BITS'((2 * TURN_COUNTS + 3) / 6);
  localparam logic [ANGLE_BITS-1:0] MOTOR3_OFFSET = ANGLE_BITS'((4 * TURN_COUNTS + 3) / 6);

  // Divider step counts: the average takes every sum bit, the phase takes
  // the angle bits plus two, since the phase quotient never exceeds 2.5 turns.
  localparam logic [STEP_W-1:0] AVG_STEPS   = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] PHASE_STEPS = STEP_W'(ANGLE_BITS + 2);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD      = 2'd2;

  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = PERIOD_W'(1000);
  localparam logic [PERIOD_W-1:0] MAX_PERIOD_RESET = PERIOD_W'(2000000);

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } rpe_div_ctl_t;

endpackage

[hw/rtl/rpe_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
module rpe_divider
  import rpe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  rpe_div_ctl_t        ctl,
  input  logic [PERIOD_W-1:0] divisor,
  input  logic [PERIOD_W-1:0] init_rem,
  input  logic [SUM_W-1:0]    dividend,
  output logic                busy,
  output logic [SUM_W-1:0]    quotient
);

  logic [PERIOD_W-1:0] rem;
  logic [SUM_W-1:0]    shreg;
  logic [STEP_W-1:0]   cnt;
  logic [PERIOD_W:0]   rem_sh;
  logic [PERIOD_W:0]   diff;
  logic                take;

  // The dividend bits leave at the top of the shift register while the
  // quotient bits enter at the bottom.
  assign rem_sh = {rem, shreg[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign take   = ~diff[PERIOD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= ctl.steps;
    end else if (busy) begin
      cnt <= cnt - STEP_W'(1);
      if (cnt == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem   <= init_rem;
      shreg <= dividend;
    end else if (busy) begin
      rem   <= take ? diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
      shreg <= {shreg[SUM_W-2:0], take};
    end
  end

  assign quotient = shreg;

endmodule

[hw/rtl/rotor_phase_estimator.sv]
// Top level of the rotor phase estimator: revolution tracking and phase output.
//
// Input items arrive on the s_ group: s_tuser carries the good flag and
// s_tdata the measured angle and the microsecond timestamp. Each accepted
// item yields exactly one result item on the m_ group: the three motor
// angles and the average revolution period in m_tdata, and the encoder_ok
// and timing_ready flags in m_tuser. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must see that it is written only
// while the block is idle, as the block itself does not enforce this. The
// single shared restoring divider first forms the average period from the
// running sum (24 steps) and then, when the sample is good and timing is
// ready, the extrapolated phase (14 steps). s_tready is high only while the
// sequencer is idle, so one item is worked on at a time.
// The result sits in an output register; the next item may be accepted while
// it still waits, and if the receiver stalls the sequencer holds its finished
// result until the output register frees. A synchronous reset clears the
// tracking state apart from the period ring entries, among it the ring fill,
// the running sum and the held angle, and restores the configuration
// defaults (encoder absent, 1000 us to 2 s).
module rotor_phase_estimator
  import rpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // angle [11:0], time_us [43:12], zero fill
  input  logic                 s_tuser,   // sample_good [0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata,   // motor1 [11:0], motor2 [23:12], motor3 [35:24],
                                          // avg_period_us [56:36], zero fill
  output logic [1:0]           m_tuser,   // encoder_ok [0], timing_ready [1]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_data
);

`include "rotor_phase_estimator_assert.svh"

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_UPDATE    = 8'b0000_0010,
    S_AVG_GO    = 8'b0000_0100,
    S_AVG_RUN   = 8'b0000_1000,
    S_CHECK     = 8'b0001_0000,
    S_PHASE_GO  = 8'b0010_0000,
    S_PHASE_RUN = 8'b0100_0000,
    S_OUT       = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic                encoder_present;
  logic [PERIOD_W-1:0] min_period_us;
  logic [PERIOD_W-1:0] max_period_us;

  // Latched input item.
  logic                  in_good;
  logic [ANGLE_BITS-1:0] in_angle;
  logic [TIME_W-1:0]     in_time;

  // Tracking state.
  logic [ANGLE_BITS-1:0] last_angle;
  logic                  angle_seen;
  logic [TIME_W-1:0]     tick_time;
  logic                  tick_seen;
  logic [PERIOD_W-1:0]   period_ring [HISTORY_DEPTH];
  logic [SLOT_W-1:0]     ring_slot;
  logic [FILL_W-1:0]     ring_fill;
  logic [SUM_W-1:0]      period_sum;
  logic [ANGLE_BITS-1:0] held_angle;
  logic [PERIOD_W-1:0]   avg_period;
  logic                  ready;

  // Combinational helpers.
  logic                  good;
  logic [TIME_W-1:0]     elapsed;
  logic                  wrapped;
  logic                  period_ok;
  logic                  ring_full;
  logic                  ring_we;
  logic [PERIOD_W-1:0]   ring_old;
  logic [PERIOD_W-1:0]   avg_now;
  logic [PERIOD_W+2:0]   ready_limit;
  logic                  ready_now;

  // Divider hookup.
  rpe_div_ctl_t        div_ctl;
  logic [PERIOD_W-1:0] div_divisor;
  logic [PERIOD_W-1:0] div_init_rem;
  logic [SUM_W-1:0]    div_dividend;
  logic                div_busy;
  logic [SUM_W-1:0]    div_quotient;

  assign s_tready = (state == S_IDLE);
  assign good     = in_good && encoder_present;

  // Time since the last tick; after the update cycle this is measured from
  // the tick that the current item may have just recorded.
  assign elapsed = in_time - tick_time;

  // A revolution is a drop from above 300 degrees to below 60 degrees.
  assign wrapped = (WRAP_W'(last_angle) * WRAP_W'(6) > WRAP_HIGH) &&
                   (WRAP_W'(in_angle) * WRAP_W'(6) < WRAP_LOW);

  assign period_ok = (elapsed >= TIME_W'(min_period_us)) &&
                     (elapsed <= TIME_W'(max_period_us));
  assign ring_full = (ring_fill >= FILL_W'(HISTORY_DEPTH));
  assign ring_old  = period_ring[ring_slot];
  assign ring_we   = (state == S_UPDATE) && good && angle_seen && wrapped &&
                     tick_seen && period_ok;

  // The divider result is meaningless for an empty ring; the average is zero.
  // The freshness limit is five halves of the average, truncated.
  assign avg_now     = (ring_fill == '0) ? '0 : div_quotient[PERIOD_W-1:0];
  assign ready_limit = ({1'b0, avg_now, 2'b00} + {3'b000, avg_now}) >> 1;
  assign ready_now   = ring_full && (avg_now != '0) && tick_seen &&
                       (elapsed <= TIME_W'(ready_limit));

  // Divider operands: the average divides the running sum by the fill count;
  // the phase divides elapsed * 2^ANGLE_BITS by the average. For the phase,
  // elapsed / 4 is already below the average, so it seeds the remainder and
  // only the two low elapsed bits and the zero angle bits are shifted in.
  // The divisor must stay put for the whole run of the division.
  always_comb begin
    div_ctl.start = (state == S_AVG_GO) || (state == S_PHASE_GO);
    if ((state == S_PHASE_GO) || (state == S_PHASE_RUN)) begin
      div_ctl.steps = PHASE_STEPS;
      div_divisor   = avg_period;
      div_init_rem  = elapsed[PERIOD_W+1:2];
      div_dividend  = {elapsed[1:0], (SUM_W-2)'(0)};
    end else begin
      div_ctl.steps = AVG_STEPS;
      div_divisor   = PERIOD_W'(ring_fill);
      div_init_rem  = '0;
      div_dividend  = period_sum;
    end
  end

  rpe_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .divisor  (div_divisor),
    .init_rem (div_init_rem),
    .dividend (div_dividend),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_present <= 1'b0;
      min_period_us   <= MIN_PERIOD_RESET;
      max_period_us   <= MAX_PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENCODER_PRESENT: encoder_present <= cfg_data[0];
        CFG_MIN_PERIOD:      min_period_us   <= cfg_data;
        CFG_MAX_PERIOD:      max_period_us   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input item latch.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_good  <= s_tuser;
      in_angle <= s_tdata[ANGLE_BITS-1:0];
      in_time  <= s_tdata[ANGLE_BITS+TIME_W-1:ANGLE_BITS];
    end
  end

  // Period ring entries need no reset: they are read only once all are written.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      period_ring[ring_slot] <= elapsed[PERIOD_W-1:0];
    end
  end

  // Sequencer and tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_angle <= '0;
      angle_seen <= 1'b0;
      tick_time  <= '0;
      tick_seen  <= 1'b0;
      ring_slot  <= '0;
      ring_fill  <= '0;
      period_sum <= '0;
      held_angle <= '0;
      avg_period <= '0;
      ready      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (!encoder_present) begin
            angle_seen <= 1'b0;
          end else if (good) begin
            last_angle <= in_angle;
            if (!angle_seen) begin
              angle_seen <= 1'b1;
            end else if (wrapped) begin
              tick_time <= in_time;
              tick_seen <= 1'b1;
              if (ring_we) begin
                if (ring_full) begin
                  period_sum <= period_sum - SUM_W'(ring_old) +
                                SUM_W'(elapsed[PERIOD_W-1:0]);
                end else begin
                  period_sum <= period_sum + SUM_W'(elapsed[PERIOD_W-1:0]);
                  ring_fill  <= ring_fill + FILL_W'(1);
                end
                ring_slot <= (ring_slot == SLOT_W'(HISTORY_DEPTH - 1)) ?
                             '0 : ring_slot + SLOT_W'(1);
              end
            end
          end
          state <= S_AVG_GO;
        end
        S_AVG_GO: begin
          state <= S_AVG_RUN;
        end
        S_AVG_RUN: begin
          if (!div_busy) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          avg_period <= avg_now;
          ready      <= ready_now;
          if (good && ready_now) begin
            state <= S_PHASE_GO;
          end else begin
            if (good) begin
              held_angle <= in_angle;
            end
            state <= S_OUT;
          end
        end
        S_PHASE_GO: begin
          state <= S_PHASE_RUN;
        end
        S_PHASE_RUN: begin
          if (!div_busy) begin
            held_angle <= div_quotient[ANGLE_BITS-1:0];
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the finished item finds it free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {7'b0, avg_period, held_angle + MOTOR3_OFFSET,
                  held_angle + MOTOR2_OFFSET, held_angle};
      m_tuser <= {ready, good};
    end
  end

  `RPE_ASSERT_IMP(a_fill_bound, 1'b1, ring_fill <= FILL_W'(HISTORY_DEPTH), "ring fill overflow")
  `RPE_ASSERT_IMP(a_empty_sum, ring_fill == '0, period_sum == '0, "sum nonzero on empty ring")
  `RPE_ASSERT_IMP(a_div_idle, state == S_IDLE, !div_busy, "divider busy while idle")
  `RPE_ASSERT_IMP(a_ready_full, m_tvalid && m_tuser[1], ring_full, "ready without full ring")
  `RPE_ASSERT_NXT(a_accept_update, s_tvalid && s_tready, state == S_UPDATE, "accept lost")

endmodule
